FILE: rtl/core/incremental_pid_speed_loop_core_macros.svh
// Assertion macros shared by the checker of the PID speed loop core.
`ifndef INCREMENTAL_PID_SPEED_LOOP_CORE_MACROS_SVH
`define INCREMENTAL_PID_SPEED_LOOP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIDSL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("PID speed loop check failed");

// Next-cycle implication, disabled during reset.
`define PIDSL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("PID speed loop check failed");

`endif

FILE: rtl/core/pidsl_pkg.sv
// Shared types and constants of the PID speed loop core.
package pidsl_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] enc_count;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [23:0] speed_filtered;
    logic               running;
  } out_t;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 8'd3;

  localparam logic [7:0]  TARGET_RST = 8'd100;
  localparam logic [15:0] GAIN_P_RST = 16'd2048;
  localparam logic [15:0] GAIN_I_RST = 16'd205;
  localparam logic [15:0] GAIN_D_RST = 16'd819;

  localparam logic [1:0] MSEL_DIV = 2'd0;
  localparam logic [1:0] MSEL_P   = 2'd1;
  localparam logic [1:0] MSEL_I   = 2'd2;
  localparam logic [1:0] MSEL_D   = 2'd3;

  // The filter sum plus two is biased by five times 2^26 so that the exact
  // reciprocal multiply by ceil(2^32/5) yields a floor division by five.
  localparam logic [30:0]        DIV5_MUL    = 31'd858993460;
  localparam logic [30:0]        DIV5_OFFSET = 31'd335544322;
  localparam logic signed [29:0] DIV5_UNBIAS = 30'sd67108864;

  localparam logic signed [29:0] FILT_MAX = 30'sd8388607;
  localparam logic signed [29:0] FILT_MIN = -30'sd8388608;
  localparam logic signed [36:0] DRIVE_MAX = 37'sd20480;
  localparam logic signed [36:0] DRIVE_MIN = -37'sd20480;

  typedef struct packed {
    logic [1:0] mul_sel;
    logic       mul_en;
    logic       filt_upd;
    logic       acc_load;
    logic       acc_add;
    logic       drv_upd;
    logic       out_load;
  } ctl_t;

endpackage

FILE: rtl/core/pidsl_mul.sv
// Shared signed multiplier with a registered product.
module pidsl_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [30:0] a,
  input  logic signed [30:0] b,
  output logic signed [61:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

FILE: rtl/core/pidsl_seq.sv
// Sequencer that steps one tick through the shared multiplier.
module pidsl_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              go_tick,
  input  logic              out_free,
  output logic              in_ready,
  output pidsl_pkg::ctl_t   ctl
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILT = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_MP   = 4'd3;
  localparam logic [3:0] ST_MI   = 4'd4;
  localparam logic [3:0] ST_MD   = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_DRV  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.mul_sel  = pidsl_pkg::MSEL_DIV;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = go_tick ? ST_FILT : ST_DONE;
        end
      end
      ST_FILT: begin
        ctl.mul_sel = pidsl_pkg::MSEL_DIV;
        ctl.mul_en  = 1'b1;
        state_nxt   = ST_ERR;
      end
      ST_ERR: begin
        ctl.filt_upd = 1'b1;
        state_nxt    = ST_MP;
      end
      ST_MP: begin
        ctl.mul_sel = pidsl_pkg::MSEL_P;
        ctl.mul_en  = 1'b1;
        state_nxt   = ST_MI;
      end
      ST_MI: begin
        ctl.mul_sel  = pidsl_pkg::MSEL_I;
        ctl.mul_en   = 1'b1;
        ctl.acc_load = 1'b1;
        state_nxt    = ST_MD;
      end
      ST_MD: begin
        ctl.mul_sel = pidsl_pkg::MSEL_D;
        ctl.mul_en  = 1'b1;
        ctl.acc_add = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_add = 1'b1;
        state_nxt   = ST_DRV;
      end
      ST_DRV: begin
        ctl.drv_upd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/incremental_pid_speed_loop_core.sv
// Top level of the incremental PID motor speed loop core.
// A running tick steps through the sequencer's states from input transfer to result
// valid, passing through the single shared 31x31 multiplier; start, stop and idle ticks
// go straight to the result state. One item is in work at a time: no new item is taken
// until the last result is loaded, but the next transfer can follow while a result waits.
// Synchronous reset restores the register defaults and clears all loop state (stopped).
module incremental_pid_speed_loop_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pidsl_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pidsl_pkg::out_t                      out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidsl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                          cfg_data
);

  pidsl_pkg::ctl_t ctl;

  logic [7:0]  target_r;
  logic [15:0] gain_p_r;
  logic [15:0] gain_i_r;
  logic [15:0] gain_d_r;

  logic signed [23:0] filter_acc_r;
  logic signed [23:0] reported_r;
  logic signed [24:0] err0_r;
  logic signed [24:0] err1_r;
  logic signed [24:0] err2_r;
  logic signed [15:0] drive_r;
  logic               run_r;
  logic signed [15:0] raw_r;
  logic signed [47:0] acc_r;

  logic               out_valid_r;
  pidsl_pkg::out_t    out_data_r;

  logic               in_xfer;
  logic               go_tick;
  logic               out_free;

  logic signed [27:0] f28;
  logic signed [27:0] raw28;
  logic signed [27:0] sum28;
  logic [30:0]        div_arg;
  logic signed [25:0] d1;
  logic signed [26:0] d2;
  logic signed [30:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [61:0] prod_r;

  logic [28:0]        quot;
  logic signed [29:0] filt_w;
  logic signed [23:0] filt;
  logic signed [24:0] tgt25;

  logic signed [47:0] acc_rnd;
  logic signed [35:0] delta;
  logic signed [36:0] drive_sum;
  logic signed [15:0] drive_new;

  assign in_xfer  = in_valid & in_ready;
  assign go_tick  = (in_data.func == pidsl_pkg::FUNC_TICK) & run_r;
  assign out_free = ~out_valid_r | out_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pidsl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .go_tick  (go_tick),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Filter numerator 3*acc + 512*raw, then biased for the divide by five.
  assign f28     = {{4{filter_acc_r[23]}}, filter_acc_r};
  assign raw28   = {{3{raw_r[15]}}, raw_r, 9'b0};
  assign sum28   = (f28 <<< 1) + f28 + raw28;
  assign div_arg = {{3{sum28[27]}}, sum28} + pidsl_pkg::DIV5_OFFSET;

  assign d1 = {err0_r[24], err0_r} - {err1_r[24], err1_r};
  assign d2 = {{2{err0_r[24]}}, err0_r} - {err1_r[24], err1_r, 1'b0}
            + {{2{err2_r[24]}}, err2_r};

  always_comb begin
    case (ctl.mul_sel)
      pidsl_pkg::MSEL_DIV: begin
        mul_a = $signed(div_arg);
        mul_b = $signed(pidsl_pkg::DIV5_MUL);
      end
      pidsl_pkg::MSEL_P: begin
        mul_a = {{5{d1[25]}}, d1};
        mul_b = $signed({15'b0, gain_p_r});
      end
      pidsl_pkg::MSEL_I: begin
        mul_a = {{6{err0_r[24]}}, err0_r};
        mul_b = $signed({15'b0, gain_i_r});
      end
      pidsl_pkg::MSEL_D: begin
        mul_a = {{4{d2[26]}}, d2};
        mul_b = $signed({15'b0, gain_d_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidsl_mul u_mul (
    .clk    (clk),
    .en     (ctl.mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign quot   = prod_r[60:32];
  assign filt_w = $signed({1'b0, quot}) - pidsl_pkg::DIV5_UNBIAS;

  always_comb begin
    if (filt_w > pidsl_pkg::FILT_MAX) begin
      filt = pidsl_pkg::FILT_MAX[23:0];
    end else if (filt_w < pidsl_pkg::FILT_MIN) begin
      filt = pidsl_pkg::FILT_MIN[23:0];
    end else begin
      filt = filt_w[23:0];
    end
  end

  assign tgt25 = $signed({9'b0, target_r, 8'b0});

  assign acc_rnd   = acc_r + 48'sd2048;
  assign delta     = acc_rnd[47:12];
  assign drive_sum = {delta[35], delta} + {{21{drive_r[15]}}, drive_r};

  always_comb begin
    if (drive_sum > pidsl_pkg::DRIVE_MAX) begin
      drive_new = pidsl_pkg::DRIVE_MAX[15:0];
    end else if (drive_sum < pidsl_pkg::DRIVE_MIN) begin
      drive_new = pidsl_pkg::DRIVE_MIN[15:0];
    end else begin
      drive_new = drive_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= pidsl_pkg::TARGET_RST;
      gain_p_r <= pidsl_pkg::GAIN_P_RST;
      gain_i_r <= pidsl_pkg::GAIN_I_RST;
      gain_d_r <= pidsl_pkg::GAIN_D_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidsl_pkg::REG_TARGET: target_r <= cfg_data[7:0];
        pidsl_pkg::REG_GAIN_P: gain_p_r <= cfg_data;
        pidsl_pkg::REG_GAIN_I: gain_i_r <= cfg_data;
        pidsl_pkg::REG_GAIN_D: gain_d_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_acc_r <= '0;
      reported_r   <= '0;
      err0_r       <= '0;
      err1_r       <= '0;
      err2_r       <= '0;
      drive_r      <= '0;
      run_r        <= 1'b0;
    end else begin
      if (in_xfer) begin
        case (in_data.func)
          pidsl_pkg::FUNC_START: begin
            run_r      <= 1'b1;
            reported_r <= '0;
            drive_r    <= '0;
            err0_r     <= '0;
            err1_r     <= '0;
            err2_r     <= '0;
          end
          pidsl_pkg::FUNC_STOP: begin
            run_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (ctl.filt_upd) begin
        filter_acc_r <= filt;
        reported_r   <= filt;
        err2_r       <= err1_r;
        err1_r       <= err0_r;
        err0_r       <= tgt25 - {filt[23], filt};
      end
      if (ctl.drv_upd) begin
        drive_r <= drive_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      raw_r <= in_data.enc_count;
    end
    if (ctl.acc_load) begin
      acc_r <= prod_r[47:0];
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + prod_r[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.drive          <= drive_r;
      out_data_r.speed_filtered <= reported_r;
      out_data_r.running        <= run_r;
    end
  end

endmodule

FILE: rtl/core/pidsl_chk.sv
// Port-level checker of the PID speed loop core and its bind.
`include "incremental_pid_speed_loop_core_macros.svh"

module pidsl_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pidsl_pkg::out_t out_data
);

  logic drive_ok;

  assign drive_ok = (out_data.drive <= 16'sd20480) && (out_data.drive >= -16'sd20480);

  `PIDSL_ASSERT_IMP(a_drive_range, out_valid, drive_ok)
  `PIDSL_ASSERT_NXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)
  `PIDSL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind incremental_pid_speed_loop_core pidsl_chk u_pidsl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the PID speed loop core, with a cycle-free model of the loop.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam longint SPEED_MAX = 8388607;
  localparam longint SPEED_MIN = -8388608;
  localparam longint DRIVE_LIM = 20480;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  pidsl_pkg::in_t                  in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  pidsl_pkg::out_t                 out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pidsl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                     cfg_data = '0;

  // Shadow copy of the registers and the loop state.
  logic [7:0]  set_target = pidsl_pkg::TARGET_RST;
  logic [15:0] k_p = pidsl_pkg::GAIN_P_RST;
  logic [15:0] k_i = pidsl_pkg::GAIN_I_RST;
  logic [15:0] k_d = pidsl_pkg::GAIN_D_RST;
  longint      loop_filter = 0;
  longint      loop_speed = 0;
  longint      err0 = 0;
  longint      err1 = 0;
  longint      err2 = 0;
  longint      loop_drive = 0;
  bit          loop_running = 1'b0;

  pidsl_pkg::out_t awaited_reports[$];
  int              mismatches = 0;
  int              effective_items = 0;
  bit              quiet = 1'b0;
  int              stall_left = 0;

  incremental_pid_speed_loop_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint floor_by(longint x, longint d);
    longint rem;
    rem = ((x % d) + d) % d;
    return (x - rem) / d;
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Advances the loop model by one item and queues the report it produces.
  task automatic advance_loop(input logic [1:0] f, input logic signed [15:0] raw);
    longint          sum;
    longint          delta;
    pidsl_pkg::out_t report;
    if (f == pidsl_pkg::FUNC_START || (f == pidsl_pkg::FUNC_TICK && loop_running)) begin
      effective_items++;
    end
    case (f)
      pidsl_pkg::FUNC_TICK: begin
        if (loop_running) begin
          sum = 3 * loop_filter + 512 * longint'(raw);
          loop_filter = limit_to(floor_by(2 * sum + 5, 10), SPEED_MIN, SPEED_MAX);
          loop_speed = loop_filter;
          err2 = err1;
          err1 = err0;
          err0 = longint'(set_target) * 256 - loop_speed;
          delta = longint'(k_p) * (err0 - err1) + longint'(k_i) * err0
                + longint'(k_d) * (err0 - 2 * err1 + err2);
          delta = (delta + 2048) >>> 12;
          loop_drive = limit_to(loop_drive + delta, -DRIVE_LIM, DRIVE_LIM);
        end
      end
      pidsl_pkg::FUNC_START: begin
        loop_running = 1'b1;
        loop_speed = 0;
        loop_drive = 0;
        err0 = 0;
        err1 = 0;
        err2 = 0;
      end
      pidsl_pkg::FUNC_STOP: begin
        loop_running = 1'b0;
      end
      default: begin
      end
    endcase
    report.drive = loop_drive[15:0];
    report.speed_filtered = loop_speed[23:0];
    report.running = loop_running;
    awaited_reports.push_back(report);
  endtask

  task automatic send_item(input logic [1:0] f, input logic signed [15:0] raw);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: f, enc_count: raw};
    do @(posedge clk); while (!in_ready);
    advance_loop(f, raw);
  endtask

  task automatic cfg_write(input logic [pidsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pidsl_pkg::REG_TARGET: set_target = value[7:0];
      pidsl_pkg::REG_GAIN_P: k_p = value;
      pidsl_pkg::REG_GAIN_I: k_i = value;
      pidsl_pkg::REG_GAIN_D: k_d = value;
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_registers(input logic [15:0] t, input logic [15:0] p,
                                input logic [15:0] i, input logic [15:0] d);
    cfg_write(pidsl_pkg::REG_TARGET, t);
    cfg_write(pidsl_pkg::REG_GAIN_P, p);
    cfg_write(pidsl_pkg::REG_GAIN_I, i);
    cfg_write(pidsl_pkg::REG_GAIN_D, d);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_results();
    repeat (12) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_speed();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 16'(int'(set_target) + int'($urandom_range(0, 40)) - 20);
    end else if (pick < 88) begin
      return 16'($urandom);
    end else if (pick < 94) begin
      return 16'sh7FFF;
    end
    return -16'sh8000;
  endfunction

  task automatic test_directed();
    send_item(pidsl_pkg::FUNC_TICK, 16'sd123);
    send_item(pidsl_pkg::FUNC_STOP, 16'sd0);
    send_item(FUNC_UNUSED, -16'sd1);
    send_item(pidsl_pkg::FUNC_START, 16'sd0);
    repeat (3) send_item(pidsl_pkg::FUNC_TICK, 16'sh7FFF);
    repeat (3) send_item(pidsl_pkg::FUNC_TICK, -16'sh8000);
    send_item(pidsl_pkg::FUNC_TICK, 16'sd0);
    send_item(pidsl_pkg::FUNC_TICK, 16'sh5555);
    send_item(pidsl_pkg::FUNC_START, -16'sd1);
    send_item(pidsl_pkg::FUNC_TICK, 16'sd100);
    send_item(FUNC_UNUSED, 16'sd7);
    send_item(pidsl_pkg::FUNC_TICK, 16'sd100);
    send_item(pidsl_pkg::FUNC_STOP, 16'sd0);
    send_item(pidsl_pkg::FUNC_TICK, -16'sh8000);
    send_item(pidsl_pkg::FUNC_STOP, 16'sh2AAA);
    send_item(pidsl_pkg::FUNC_START, 16'sd0);
    send_item(pidsl_pkg::FUNC_TICK, 16'sd99);
    send_item(pidsl_pkg::FUNC_TICK, 16'sd101);
  endtask

  task automatic run_loop_burst(input int ticks);
    send_item(pidsl_pkg::FUNC_START, 16'($urandom));
    repeat (ticks) send_item(pidsl_pkg::FUNC_TICK, pick_speed());
  endtask

  task automatic test_register_extremes();
    wait_idle();
    load_registers(16'd0, 16'd0, 16'd0, 16'd0);
    run_loop_burst(20);
    wait_idle();
    load_registers(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_loop_burst(30);
    wait_idle();
    // Writes to indexes outside the register map must leave the setting alone.
    cfg_write(8'd4, 16'hFFFF);
    cfg_write(8'hFF, 16'h0000);
    load_registers(16'd200, 16'd4096, 16'd410, 16'd1638);
    run_loop_burst(30);
    send_item(pidsl_pkg::FUNC_STOP, 16'sd0);
  endtask

  task automatic run_random_block(input int quota, input bit pause_midway);
    int  first;
    int  pick;
    bit  paused;
    first = effective_items;
    paused = 1'b0;
    while (effective_items - first < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(pidsl_pkg::FUNC_STOP, 16'($urandom));
      end else if (pick < 14) begin
        send_item(FUNC_UNUSED, 16'($urandom));
      end else if (pick < 18) begin
        send_item(pidsl_pkg::FUNC_TICK, 16'($urandom));
      end else begin
        run_loop_burst($urandom_range(1, 60));
      end
      if (pause_midway && !paused && effective_items - first >= quota / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      wait_idle();
      if (phase == 4) begin
        quiet = 1'b1;
      end
      if (phase == 1) begin
        load_registers(16'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                       16'($urandom));
      end else begin
        load_registers(16'($urandom_range(0, 255)), 16'($urandom_range(0, 8191)),
                       16'($urandom_range(0, 1023)), 16'($urandom_range(0, 4095)));
      end
      run_random_block(240, phase == 2);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic flag_field(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    pidsl_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer expected none actual %h", $time, out_data);
      end else begin
        want = awaited_reports.pop_front();
        if (out_data.drive !== want.drive) begin
          flag_field("drive", want.drive, out_data.drive);
        end
        if (out_data.speed_filtered !== want.speed_filtered) begin
          flag_field("speed_filtered", want.speed_filtered, out_data.speed_filtered);
        end
        if (out_data.running !== want.running) begin
          flag_field("running", want.running, out_data.running);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/pidsl_pkg.sv
rtl/core/pidsl_mul.sv
rtl/core/pidsl_seq.sv
rtl/core/incremental_pid_speed_loop_core.sv
rtl/core/pidsl_chk.sv
sim/tb_top.sv
